// ===== hw/rtl/ncts_pkg.sv =====
package ncts_pkg;

    localparam int NUM_VOICES = 4;
    localparam int NOTE_W     = 7;
    localparam int LEN_W      = 24;
    localparam int GAIN_W     = 16;
    localparam int SAMPLE_W   = 16;
    localparam int KEY_W      = 8;
    localparam int MIX_W      = 18;
    localparam int MAG_W      = MIX_W - 1;
    localparam int PROD_W     = MAG_W + GAIN_W;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic [14:0] AMP_MAX     = 15'd32767;
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // semitone ratios 2^(i/12) in q30
    localparam logic [30:0] SEMIS_Q30 [12] = '{
        31'd1073741824, 31'd1137589836, 31'd1205234447, 31'd1276901417,
        31'd1352829926, 31'd1433273380, 31'd1518500250, 31'd1608794974,
        31'd1704458901, 31'd1805811301, 31'd1913190429, 31'd2026954652
    };

    // major chord: root, third, fifth, octave
    localparam logic [3:0] CHORD_OFFS [NUM_VOICES] = '{4'd0, 4'd4, 4'd7, 4'd12};

    typedef struct packed {
        logic                action;
        logic [NOTE_W-1:0]   note;
        logic                chord;
        logic [LEN_W-1:0]    length_samples;
        logic [GAIN_W-1:0]   loudness;
    } t_cmd;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last;
    } t_smp;

    // one tick that produces a sample, handed to the mix stage
    typedef struct packed {
        logic              fire;
        logic              chord;
        logic [GAIN_W-1:0] gain;
        logic              last;
    } t_s1_ctl;

    typedef struct packed {
        logic s1_ready;
        logic s1_busy;
    } t_mix_stat;

    // sin(x) in q30 for 0 <= x <= pi/2, taylor series to x^13 (elaboration only)
    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 156;
        t  = Q30_ONE - ((x2 * t) >> 30) / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        return (x * t) >> 30;
    endfunction

endpackage

// ===== hw/rtl/ncts_stream_if.sv =====
interface ncts_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/note_chord_tone_synth.sv =====
// path: an accepted tick is registered in the sine rom read register, then in the
//   output register, from which its sample leaves o_smp
// throughput: one transaction per cycle, load or tick, except when o_smp stalls;
//   the sine rom read register and the output register form the two stages of a sample
// reset: synchronous, active low; clears note state, phases and valid flags
// the sine and key tables are constants and need no clearing pass
module note_chord_tone_synth #(
    parameter int SAMPLE_RATE      = 44100,
    parameter int PHASE_BITS       = 32,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int KEY_TABLE_DEPTH  = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ncts_stream_if.sink   i_cmd,
    ncts_stream_if.source o_smp
);
    import ncts_pkg::*;

    localparam int SINE_AW = $clog2(SINE_TABLE_DEPTH);

    t_s1_ctl                    s1_ctl;
    t_mix_stat                  mix_stat;
    logic [SINE_AW-1:0]         sine_addr [NUM_VOICES];
    logic signed [SAMPLE_W-1:0] sine_data [NUM_VOICES];

    ncts_voice_ctl #(
        .SAMPLE_RATE      (SAMPLE_RATE),
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .KEY_TABLE_DEPTH  (KEY_TABLE_DEPTH)
    ) u_voice_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_s1_ready (mix_stat.s1_ready),
        .o_ctl      (s1_ctl),
        .o_addr     (sine_addr)
    );

    // one table copy per voice so all four read in the same cycle
    for (genvar v = 0; v < NUM_VOICES; v++) begin : g_rom
        ncts_sine_rom #(
            .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
        ) u_sine_rom (
            .i_clk  (i_clk),
            .i_en   (s1_ctl.fire),
            .i_addr (sine_addr[v]),
            .o_data (sine_data[v])
        );
    end

    ncts_mixer u_mixer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s1_ctl),
        .i_sine  (sine_data),
        .o_stat  (mix_stat),
        .o_smp   (o_smp)
    );

    a_fire_is_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_ctl.fire |-> (i_cmd.valid && i_cmd.ready && i_cmd.payload.action == ACT_TICK))
        else $error("sample stage loaded without an accepted tick");

    a_fire_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_ctl.fire |=> mix_stat.s1_busy)
        else $error("accepted tick lost before the mix stage");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mix_stat.s1_busy && o_smp.valid && !o_smp.ready) |-> !i_cmd.ready)
        else $error("input ready while both stages are full and stalled");

    a_busy_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mix_stat.s1_busy && !o_smp.valid) |=> o_smp.valid)
        else $error("pending sample not moved into the output register");

endmodule

// ===== hw/rtl/ncts_sine_rom.sv =====
module ncts_sine_rom #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] i_addr,
    output logic signed [ncts_pkg::SAMPLE_W-1:0] o_data
);
    import ncts_pkg::*;

    localparam logic [63:0] DEPTH64 = 64'(SINE_TABLE_DEPTH);

    typedef logic signed [SAMPLE_W-1:0] t_sine_rom [SINE_TABLE_DEPTH];

    // full-wave table, quarter-wave folded before the series
    function automatic t_sine_rom build_rom();
        t_sine_rom   rom;
        logic [63:0] four;
        logic [63:0] quad;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] amp;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            four = 64'(i) * 64'd4;
            quad = four / DEPTH64;
            r    = four - quad * DEPTH64;
            if (quad[0]) begin
                r = DEPTH64 - r;
            end
            x   = (r * HALF_PI_Q30 + (DEPTH64 >> 1)) / DEPTH64;
            s   = sin_q30(x);
            amp = (s * 64'(AMP_MAX) + (Q30_ONE >> 1)) >> 30;
            rom[i] = quad[1] ? -amp[SAMPLE_W-1:0] : amp[SAMPLE_W-1:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_rom();

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_data <= SINE_ROM[i_addr];
        end
    end

endmodule

// ===== hw/rtl/ncts_voice_ctl.sv =====
module ncts_voice_ctl #(
    parameter int SAMPLE_RATE      = 44100,
    parameter int PHASE_BITS       = 32,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int KEY_TABLE_DEPTH  = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ncts_stream_if.sink                         i_cmd,
    input  logic                                i_s1_ready,
    output ncts_pkg::t_s1_ctl                   o_ctl,
    output logic [$clog2(SINE_TABLE_DEPTH)-1:0] o_addr [ncts_pkg::NUM_VOICES]
);
    import ncts_pkg::*;

    localparam int SINE_AW  = $clog2(SINE_TABLE_DEPTH);
    localparam int KEY_AW   = $clog2(KEY_TABLE_DEPTH);
    localparam int IDX_W    = PHASE_BITS + SINE_AW;
    localparam logic [63:0] SR64 = 64'(SAMPLE_RATE);

    typedef logic [PHASE_BITS-1:0] t_key_rom [KEY_TABLE_DEPTH];

    // phase increment per key, equal temperament with a4 at key 49
    function automatic t_key_rom build_key_rom();
        t_key_rom    rom;
        int          d;
        int          oct;
        int          e;
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] mask;
        mask = (64'd1 << PHASE_BITS) - 64'd1;
        for (int k = 0; k < KEY_TABLE_DEPTH; k++) begin
            d   = k + 11;
            oct = d / 12 - 5;
            num = 64'd440 * 64'(SEMIS_Q30[d % 12]);
            e   = PHASE_BITS - 30 + oct;
            if (e < 0) begin
                q = ((num + ((SR64 << (-e)) >> 1)) >> (-e)) / SR64;
            end else begin
                q   = (num / SR64) & mask;
                rem = num % SR64;
                for (int j = 0; j < e; j++) begin
                    rem = rem << 1;
                    q   = (q << 1) & mask;
                    if (rem >= SR64) begin
                        rem = rem - SR64;
                        q   = q | 64'd1;
                    end
                end
                if ((rem << 1) >= SR64) begin
                    q = q + 64'd1;
                end
            end
            rom[k] = q[PHASE_BITS-1:0];
        end
        return rom;
    endfunction

    localparam t_key_rom KEY_ROM = build_key_rom();

    logic [PHASE_BITS-1:0] r_phase [NUM_VOICES];
    logic [PHASE_BITS-1:0] n_phase [NUM_VOICES];
    logic [LEN_W-1:0]      r_samples_left;
    logic [NOTE_W-1:0]     r_key;
    logic                  r_chord;
    logic [GAIN_W-1:0]     r_gain;

    logic accept;
    logic load;
    logic tick;

    assign i_cmd.ready = i_s1_ready;
    assign accept = i_cmd.valid && i_cmd.ready;
    assign load   = accept && (i_cmd.payload.action == ACT_LOAD);
    assign tick   = accept && (i_cmd.payload.action == ACT_TICK) && (r_samples_left != '0);

    assign o_ctl.fire  = tick;
    assign o_ctl.chord = r_chord;
    assign o_ctl.gain  = r_gain;
    assign o_ctl.last  = (r_samples_left == LEN_W'(1));

    always_comb begin
        logic [KEY_W-1:0]  key;
        logic [IDX_W-1:0]  idx;
        for (int v = 0; v < NUM_VOICES; v++) begin
            // voice key beyond the table stays silent
            key = {1'b0, r_key} + KEY_W'(CHORD_OFFS[v]);
            if (key < KEY_TABLE_DEPTH) begin
                n_phase[v] = r_phase[v] + KEY_ROM[key[KEY_AW-1:0]];
            end else begin
                n_phase[v] = r_phase[v];
            end
            // constant multiply, a plain bit select for power-of-two depths
            idx = IDX_W'(r_phase[v]) * IDX_W'(SINE_TABLE_DEPTH);
            o_addr[v] = idx[IDX_W-1:PHASE_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples_left <= '0;
            r_key          <= '0;
            r_chord        <= 1'b0;
            r_gain         <= '0;
            for (int v = 0; v < NUM_VOICES; v++) begin
                r_phase[v] <= '0;
            end
        end else if (load) begin
            r_samples_left <= i_cmd.payload.length_samples;
            r_key          <= i_cmd.payload.note;
            r_chord        <= i_cmd.payload.chord;
            r_gain         <= i_cmd.payload.loudness;
            for (int v = 0; v < NUM_VOICES; v++) begin
                r_phase[v] <= '0;
            end
        end else if (tick) begin
            r_samples_left <= r_samples_left - LEN_W'(1);
            for (int v = 0; v < NUM_VOICES; v++) begin
                r_phase[v] <= n_phase[v];
            end
        end
    end

endmodule

// ===== hw/rtl/ncts_mixer.sv =====
module ncts_mixer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ncts_pkg::t_s1_ctl                    i_ctl,
    input  logic signed [ncts_pkg::SAMPLE_W-1:0] i_sine [ncts_pkg::NUM_VOICES],
    output ncts_pkg::t_mix_stat                  o_stat,
    ncts_stream_if.source                        o_smp
);
    import ncts_pkg::*;

    logic              r_s1_valid;
    logic              r_chord;
    logic [GAIN_W-1:0] r_gain;
    logic              r_last;

    logic                       r_o_valid;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_o_last;

    logic                       s2_load;
    logic signed [MIX_W-1:0]    mix;
    logic [MAG_W-1:0]           mag;
    logic [PROD_W-1:0]          prod;
    logic [PROD_W-1:0]          scaled;
    logic [SAMPLE_W-1:0]        sat;
    logic signed [SAMPLE_W-1:0] n_sample;

    assign s2_load = r_s1_valid && (!r_o_valid || o_smp.ready);

    assign o_stat.s1_ready = !r_s1_valid || s2_load;
    assign o_stat.s1_busy  = r_s1_valid;

    always_comb begin
        logic signed [MIX_W-1:0] sum;
        logic signed [MIX_W-1:0] absval;
        sum = '0;
        for (int v = 0; v < NUM_VOICES; v++) begin
            sum = sum + MIX_W'(i_sine[v]);
        end
        mix    = r_chord ? sum : MIX_W'(i_sine[0]);
        absval = mix[MIX_W-1] ? -mix : mix;
        mag    = absval[MAG_W-1:0];
        prod   = PROD_W'(mag) * PROD_W'(r_gain);
        // chord averages four voices: two more bits of shift
        scaled = r_chord ? (prod >> 16) : (prod >> 14);
        if (scaled > PROD_W'(AMP_MAX)) begin
            sat = SAMPLE_W'(AMP_MAX);
        end else begin
            sat = scaled[SAMPLE_W-1:0];
        end
        n_sample = mix[MIX_W-1] ? -sat : sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_ctl.fire) begin
                r_s1_valid <= 1'b1;
            end else if (s2_load) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_load) begin
                r_o_valid <= 1'b1;
            end else if (o_smp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fire) begin
            r_chord <= i_ctl.chord;
            r_gain  <= i_ctl.gain;
            r_last  <= i_ctl.last;
        end
        if (s2_load) begin
            r_sample <= n_sample;
            r_o_last <= r_last;
        end
    end

    assign o_smp.valid         = r_o_valid;
    assign o_smp.payload.left  = r_sample;
    assign o_smp.payload.right = r_sample;
    assign o_smp.payload.last  = r_o_last;

endmodule
